// ===== src/a2bc_pkg.sv =====
// shared types and constants for the argon2 block compression
// no dependencies
package a2bc_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned PairW = 2 * WordW;
  localparam int unsigned Pairs = 64;
  localparam int unsigned PairAw = $clog2(Pairs);

  // input item: two words of each source block
  typedef struct packed {
    logic [WordW-1:0] x_even;
    logic [WordW-1:0] x_odd;
    logic [WordW-1:0] y_even;
    logic [WordW-1:0] y_odd;
  } in_t;

  // result item
  typedef struct packed {
    logic [WordW-1:0] out_even;
    logic [WordW-1:0] out_odd;
    logic             last_out;
  } out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_MUL,
    ST_ADD,
    ST_WRITE,
    ST_EMIT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic              in_we;
    logic [PairAw-1:0] in_addr;
    logic              rd_en;
    logic              rd_from_r;
    logic [PairAw-1:0] rd_addr;
    logic [2:0]        pair;
    logic              mul_en;
    logic              add_en;
    logic [1:0]        step;
    logic              diag;
    logic              wr_en;
    logic [PairAw-1:0] wr_addr;
    logic              emit;
    logic              last;
  } cmd_t;

endpackage

// ===== src/a2bc_ctrl.sv =====
// controller for the argon2 block compression: load, permutation and emit sequencing
// depends on a2bc_pkg
module a2bc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output a2bc_pkg::cmd_t cmd_o
);
  import a2bc_pkg::*;

  state_e      state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [3:0]  perm_q, perm_d;
  logic [1:0]  step_q, step_d;
  logic        rnd_q, rnd_d;
  logic [5:0]  load_q, load_d;
  logic [5:0]  addr;

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      perm_q  <= '0;
      step_q  <= '0;
      rnd_q   <= 1'b0;
      load_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      perm_q  <= perm_d;
      step_q  <= step_d;
      rnd_q   <= rnd_d;
      load_q  <= load_d;
    end
  end

  // pair address: rows in the first half of the passes, columns after
  assign addr = perm_q[3] ? {cnt_q[2:0], perm_q[2:0]} : {perm_q[2:0], cnt_q[2:0]};

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    perm_d  = perm_q;
    step_d  = step_q;
    rnd_d   = rnd_q;
    load_d  = load_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    cmd_o.diag = rnd_q;
    cmd_o.pair = cnt_q[2:0];
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.in_we   = start_i;
        cmd_o.in_addr = load_q;
        if (start_i) begin
          load_d = load_q + 6'd1;
          if (load_q == 6'd63) begin
            state_d = ST_READ;
            cnt_d   = '0;
            perm_d  = '0;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en     = (cnt_q[3] == 1'b0);
        cmd_o.rd_from_r = !perm_q[3];
        cmd_o.rd_addr   = addr;
        if (cnt_q[3]) begin
          state_d = ST_MUL;
          cnt_d   = '0;
          step_d  = '0;
          rnd_d   = 1'b0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add_en = 1'b1;
        if (step_q == 2'd3) begin
          if (rnd_q) begin
            state_d = ST_WRITE;
            cnt_d   = '0;
          end else begin
            rnd_d   = 1'b1;
            step_d  = '0;
            state_d = ST_MUL;
          end
        end else begin
          step_d  = step_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = addr;
        if (cnt_q[2:0] == 3'd7) begin
          cnt_d = '0;
          if (perm_q == 4'd15) begin
            state_d = ST_EMIT;
          end else begin
            perm_d  = perm_q + 4'd1;
            state_d = ST_READ;
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_EMIT: begin
        cmd_o.emit    = 1'b1;
        cmd_o.rd_addr = cnt_q;
        cmd_o.last    = (cnt_q == 6'd63);
        cnt_d         = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign busy_o = (state_q != ST_LOAD);

  // checks
  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && cnt_q == 6'd63) |=> state_q == ST_LOAD)
    else $error("emit did not return to load");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.in_we |-> !busy_o)
    else $error("input write while busy");
  a_perm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD && step_q == 2'd3 && rnd_q) |=> state_q == ST_WRITE)
    else $error("permutation end missed write-back");

endmodule

// ===== src/a2bc_datapath.sv =====
// datapath for the argon2 block compression: block stores, working row and four mixing lanes
// depends on a2bc_pkg
module a2bc_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  a2bc_pkg::in_t  in_i,
  input  a2bc_pkg::cmd_t cmd_i,
  output a2bc_pkg::out_t out_o,
  output logic           out_valid_o
);
  import a2bc_pkg::*;

  logic [PairW-1:0] r_mem [Pairs];
  logic [PairW-1:0] q_mem [Pairs];
  logic [PairW-1:0] r_rd_q, q_rd_q;
  logic [WordW-1:0] v_q [16];
  logic [WordW-1:0] prod_q [4];
  logic [WordW-1:0] sum [4];
  logic [WordW-1:0] rot [4];
  logic [3:0]       xi [4];
  logic [3:0]       zi [4];
  logic             cap_q, cap_src_q, ov_q, last_q;
  logic [2:0]       cap_pair_q;

  // xor store, written per input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_we) begin
      r_mem[cmd_i.in_addr] <= {in_i.x_odd ^ in_i.y_odd, in_i.x_even ^ in_i.y_even};
    end
    if (cmd_i.rd_en || cmd_i.emit) begin
      r_rd_q <= r_mem[cmd_i.rd_addr];
    end
  end

  // work store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      q_mem[cmd_i.wr_addr] <= {v_q[{cmd_i.pair, 1'b1}], v_q[{cmd_i.pair, 1'b0}]};
    end
    if (cmd_i.rd_en || cmd_i.emit) begin
      q_rd_q <= q_mem[cmd_i.rd_addr];
    end
  end

  // read-capture and output flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= 1'b0;
      ov_q   <= 1'b0;
      last_q <= 1'b0;
    end else begin
      cap_q  <= cmd_i.rd_en;
      ov_q   <= cmd_i.emit;
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_pair_q <= cmd_i.pair;
    cap_src_q  <= cmd_i.rd_from_r;
  end

  // four mixing lanes, columns then diagonals
  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam logic [3:0] IA  = 4'(l);
    localparam logic [3:0] IB0 = 4'(4 + l);
    localparam logic [3:0] IB1 = 4'(4 + ((l + 1) % 4));
    localparam logic [3:0] IC0 = 4'(8 + l);
    localparam logic [3:0] IC1 = 4'(8 + ((l + 2) % 4));
    localparam logic [3:0] ID0 = 4'(12 + l);
    localparam logic [3:0] ID1 = 4'(12 + ((l + 3) % 4));
    logic [3:0]       ib, ic, id, yi;
    logic [WordW-1:0] xv, yv, zx;

    assign ib = cmd_i.diag ? IB1 : IB0;
    assign ic = cmd_i.diag ? IC1 : IC0;
    assign id = cmd_i.diag ? ID1 : ID0;
    // even steps mix a with b into d, odd steps c with d into b
    assign xi[l] = cmd_i.step[0] ? ic : IA;
    assign yi    = cmd_i.step[0] ? id : ib;
    assign zi[l] = cmd_i.step[0] ? ib : id;
    assign xv    = v_q[xi[l]];
    assign yv    = v_q[yi];

    always_ff @(posedge clk_i) begin
      if (cmd_i.mul_en) begin
        prod_q[l] <= xv[31:0] * yv[31:0];
      end
    end

    assign sum[l] = xv + yv + {prod_q[l][WordW-2:0], 1'b0};
    assign zx     = v_q[zi[l]] ^ sum[l];

    always_comb begin
      case (cmd_i.step)
        2'd0:    rot[l] = {zx[31:0], zx[63:32]};
        2'd1:    rot[l] = {zx[23:0], zx[63:24]};
        2'd2:    rot[l] = {zx[15:0], zx[63:16]};
        default: rot[l] = {zx[62:0], zx[63]};
      endcase
    end
  end

  // working row registers
  always_ff @(posedge clk_i) begin
    if (cap_q) begin
      v_q[{cap_pair_q, 1'b0}] <= cap_src_q ? r_rd_q[WordW-1:0]     : q_rd_q[WordW-1:0];
      v_q[{cap_pair_q, 1'b1}] <= cap_src_q ? r_rd_q[PairW-1:WordW] : q_rd_q[PairW-1:WordW];
    end
    if (cmd_i.add_en) begin
      for (int l = 0; l < 4; l++) begin
        v_q[xi[l]] <= sum[l];
        v_q[zi[l]] <= rot[l];
      end
    end
  end

  // result transfer
  assign out_o.out_even = q_rd_q[WordW-1:0] ^ r_rd_q[WordW-1:0];
  assign out_o.out_odd  = q_rd_q[PairW-1:WordW] ^ r_rd_q[PairW-1:WordW];
  assign out_o.last_out = last_q;
  assign out_valid_o    = ov_q;

  // checks
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && last_q) |=> !ov_q)
    else $error("result after last");
  a_wr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> !(cmd_i.rd_en || cmd_i.emit || cmd_i.in_we))
    else $error("store access clash");
  a_cap_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q |-> !(cmd_i.add_en || cmd_i.mul_en))
    else $error("capture during mixing");

endmodule

// ===== src/argon2_block_compress.sv =====
// argon2 compression g: 64 input transfers per block pair, 64 result transfers
// the 64th input starts 16 permutations, each of 8 reads plus a capture,
// 4 lanes x 4 mul/add steps per half round and 8 write-backs
// results then follow one per cycle; receiver cannot stall
// rst_ni clears control only; the block stores are undefined until loaded
module argon2_block_compress (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  a2bc_pkg::in_t  in_i,
  output a2bc_pkg::out_t out_o,
  output logic           out_valid_o
);
  import a2bc_pkg::*;

  cmd_t cmd;

  a2bc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  a2bc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .out_o       (out_o),
    .out_valid_o (out_valid_o)
  );

endmodule

// ===== verif/tb_argon2_block_compress.sv =====
// testbench for argon2_block_compress: blamka compression of block pairs, checked per result
// depends on a2bc_pkg and the argon2_block_compress rtl
module tb_argon2_block_compress;
  timeunit 1ns;
  timeprecision 1ps;
  import a2bc_pkg::*;

  localparam int unsigned Words = 128;
  localparam longint unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_i = '0;
  out_t out_o;
  logic out_valid_o;

  argon2_block_compress u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .out_o       (out_o),
    .out_valid_o (out_valid_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [WordW-1:0] r_blk [Words];
  logic [WordW-1:0] q_blk [Words];
  logic [PairAw-1:0] pair_idx = '0;
  out_t result_q [$];
  int unsigned mismatches = 0;
  longint unsigned cycles = 0;
  bit burst_on = 1'b1;
  int unsigned burst_left = 0;

  function automatic logic [WordW-1:0] mul_add(logic [WordW-1:0] a, logic [WordW-1:0] b);
    logic [WordW-1:0] prod;
    prod = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    return a + b + (prod << 1);
  endfunction

  function automatic logic [WordW-1:0] rot_r(logic [WordW-1:0] v, int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  // quarter mix on a 16-word vector
  task automatic quarter_mix(inout logic [WordW-1:0] v [16], input int a, b, c, d);
    v[a] = mul_add(v[a], v[b]);
    v[d] = rot_r(v[d] ^ v[a], 32);
    v[c] = mul_add(v[c], v[d]);
    v[b] = rot_r(v[b] ^ v[c], 24);
    v[a] = mul_add(v[a], v[b]);
    v[d] = rot_r(v[d] ^ v[a], 16);
    v[c] = mul_add(v[c], v[d]);
    v[b] = rot_r(v[b] ^ v[c], 63);
  endtask

  task automatic blamka_round(inout logic [WordW-1:0] v [16]);
    quarter_mix(v, 0, 4, 8, 12);
    quarter_mix(v, 1, 5, 9, 13);
    quarter_mix(v, 2, 6, 10, 14);
    quarter_mix(v, 3, 7, 11, 15);
    quarter_mix(v, 0, 5, 10, 15);
    quarter_mix(v, 1, 6, 11, 12);
    quarter_mix(v, 2, 7, 8, 13);
    quarter_mix(v, 3, 4, 9, 14);
  endtask

  // work out the result block once the last pair is in
  task automatic compress_predict();
    logic [WordW-1:0] v [16];
    out_t res;
    for (int w = 0; w < Words; w++) q_blk[w] = r_blk[w];
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 16; k++) v[k] = q_blk[16*i + k];
      blamka_round(v);
      for (int k = 0; k < 16; k++) q_blk[16*i + k] = v[k];
    end
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        v[2*j] = q_blk[16*j + 2*i];
        v[2*j+1] = q_blk[16*j + 2*i + 1];
      end
      blamka_round(v);
      for (int j = 0; j < 8; j++) begin
        q_blk[16*j + 2*i] = v[2*j];
        q_blk[16*j + 2*i + 1] = v[2*j+1];
      end
    end
    for (int n = 0; n < Pairs; n++) begin
      res.out_even = q_blk[2*n] ^ r_blk[2*n];
      res.out_odd = q_blk[2*n+1] ^ r_blk[2*n+1];
      res.last_out = (n == Pairs - 1);
      result_q.push_back(res);
    end
  endtask

  // send one item, with burst/gap idling; predict on acceptance
  // start stays high between items of a burst and drops only for a gap
  task automatic send_pair(in_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_i <= item;
    // busy is stable mid-cycle; the following edge is the accepting one
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    r_blk[2*pair_idx] = item.x_even ^ item.y_even;
    r_blk[2*pair_idx+1] = item.x_odd ^ item.y_odd;
    if (pair_idx == PairAw'(Pairs - 1)) compress_predict();
    pair_idx++;
  endtask

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WordW-1:0] edge_word(int sel);
    case (sel % 6)
      0: return '0;
      1: return '1;
      2: return 64'h0000_0000_FFFF_FFFF;
      3: return 64'hFFFF_FFFF_0000_0000;
      4: return 64'h8000_0000_0000_0001;
      default: return rand_word();
    endcase
  endfunction

  // one full block pair of given kind
  task automatic send_block(int kind);
    in_t item;
    for (int k = 0; k < Pairs; k++) begin
      case (kind)
        0: item = '0;
        1: item = {4{64'hFFFF_FFFF_FFFF_FFFF}};
        2: item = {edge_word(k), edge_word(k + 1), edge_word(k + 2), edge_word(k + 3)};
        default: item = {rand_word(), rand_word(), rand_word(), rand_word()};
      endcase
      send_pair(item);
    end
  endtask

  // directed: all-zero, all-ones and mixed extremes
  task automatic test_directed();
    send_block(0);
    send_block(1);
    send_block(2);
  endtask

  // hold off until every result of the pending block is out
  task automatic test_drain_pause();
    send_block(3);
    start <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    send_block(2);
  endtask

  // random blocks with bursty sender
  task automatic test_random();
    for (int b = 0; b < 2; b++) send_block($urandom_range(0, 4) == 0 ? 2 : 3);
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", out_o);
      end else begin
        want = result_q.pop_front();
        if (out_o.out_even !== want.out_even || out_o.out_odd !== want.out_odd ||
            out_o.last_out !== want.last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %b, got %h %h %b", want.out_even,
                     want.out_odd, want.last_out, out_o.out_even, out_o.out_odd,
                     out_o.last_out);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random();
    start <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== argon2_block_compress.f =====
src/a2bc_pkg.sv
src/a2bc_ctrl.sv
src/a2bc_datapath.sv
src/argon2_block_compress.sv
verif/tb_argon2_block_compress.sv
